[rtl/array_deque_engine_top_assert.svh]
// Assertion macros shared by the deque engine modules.
`ifndef ARRAY_DEQUE_ENGINE_TOP_ASSERT_SVH
`define ARRAY_DEQUE_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ADE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ADE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ade_pkg.sv]
package ade_pkg;

  localparam int REQ_W     = 3;
  localparam int VAL_W     = 32;
  localparam int STS_W     = 3;
  localparam int CNT_W     = 9;
  localparam int CAP_W     = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [REQ_W-1:0] REQ_PUSH_REAR  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_REAR   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 3'd4;

  localparam logic [STS_W-1:0] STS_OK       = 3'd0;
  localparam logic [STS_W-1:0] STS_FULL     = 3'd1;
  localparam logic [STS_W-1:0] STS_BOUNDARY = 3'd2;
  localparam logic [STS_W-1:0] STS_EMPTY    = 3'd3;
  localparam logic [STS_W-1:0] STS_REFUSED  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd1;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 9'd256;

  localparam logic MODE_INPUT_RESTRICTED  = 1'b0;
  localparam logic MODE_OUTPUT_RESTRICTED = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ade_cmd_t;

endpackage

[rtl/ade_mem.sv]
module ade_mem #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = 8
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/ade_ctrl.sv]
module ade_ctrl
  import ade_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ade_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`include "array_deque_engine_top_assert.svh"

  `ADE_ASSERT_NOW(a_ready_excl, 1'b1, !(in_ready && out_valid), "ready and valid overlap")
  `ADE_ASSERT_NEXT(a_load_exec, cmd.load, cmd.exec, "accepted item not executed")
  `ADE_ASSERT_NEXT(a_exec_out, cmd.exec, out_valid && !in_ready, "executed item not shown")

endmodule

[rtl/ade_dp.sv]
module ade_dp
  import ade_pkg::*;
#(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ade_cmd_t                cmd,
  input  logic [REQ_W-1:0]        req_type,
  input  logic signed [VAL_W-1:0] push_value,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CAP_W-1:0]        cfg_data,
  output logic [STS_W-1:0]        status,
  output logic signed [VAL_W-1:0] read_value,
  output logic [CNT_W-1:0]        count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = ((PTR_W > CAP_W) ? PTR_W : CAP_W) + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // configuration
  logic [CAP_W-1:0] capacity;
  logic             restrict_mode;

  // deque state
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic             is_empty;
  logic [CNT_W-1:0] stored_count;

  // latched request
  logic [REQ_W-1:0] req_q;
  logic [VAL_W-1:0] val_q;

  // result
  logic [STS_W-1:0] status_q;
  logic             rd_ok_q;

  logic [PTR_W-1:0] head_next;
  logic [PTR_W-1:0] tail_next;
  logic             empty_next;
  logic [CNT_W-1:0] count_next;
  logic [STS_W-1:0] sts_c;
  logic             wr_c;
  logic [PTR_W-1:0] wr_addr;
  logic [PTR_W-1:0] rd_addr;
  logic             rd_ok_c;

  logic [CW-1:0] cap_ext;
  logic [CW-1:0] cap_eff;
  logic          full;
  logic          at_rear;
  logic          refused;
  logic          is_push;

  logic [DATA_WIDTH-1:0] rd_data;
  logic [63:0]           rd_wide;

  always_comb begin
    cap_ext = CW'(capacity);
    if (capacity == '0) begin
      cap_eff = CW'(1);
    end else if (cap_ext > DEPTH_C) begin
      cap_eff = DEPTH_C;
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign full    = CW'(stored_count) >= cap_eff;
  assign at_rear = CW'(tail) >= (cap_eff - CW'(1));
  assign is_push = (req_q == REQ_PUSH_REAR) || (req_q == REQ_PUSH_FRONT);
  assign refused = (req_q > REQ_PEEK_FRONT) ||
                   ((req_q == REQ_PUSH_FRONT) && (restrict_mode == MODE_INPUT_RESTRICTED)) ||
                   ((req_q == REQ_POP_REAR) && (restrict_mode == MODE_OUTPUT_RESTRICTED));

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    empty_next = is_empty;
    count_next = stored_count;
    sts_c      = STS_OK;
    wr_c       = 1'b0;
    wr_addr    = tail;
    rd_addr    = head;
    rd_ok_c    = 1'b0;
    if (refused) begin
      sts_c = STS_REFUSED;
    end else if (is_push) begin
      if (full) begin
        sts_c = STS_FULL;
      end else if (is_empty) begin
        head_next  = '0;
        tail_next  = '0;
        empty_next = 1'b0;
        count_next = stored_count + CNT_W'(1);
        wr_c       = 1'b1;
        wr_addr    = '0;
      end else if (req_q == REQ_PUSH_REAR) begin
        if (at_rear) begin
          sts_c = STS_BOUNDARY;
        end else begin
          tail_next  = tail + PTR_W'(1);
          count_next = stored_count + CNT_W'(1);
          wr_c       = 1'b1;
          wr_addr    = tail + PTR_W'(1);
        end
      end else begin
        if (head == '0) begin
          sts_c = STS_BOUNDARY;
        end else begin
          head_next  = head - PTR_W'(1);
          count_next = stored_count + CNT_W'(1);
          wr_c       = 1'b1;
          wr_addr    = head - PTR_W'(1);
        end
      end
    end else if (is_empty) begin
      sts_c = STS_EMPTY;
    end else if (req_q == REQ_PEEK_FRONT) begin
      rd_ok_c = 1'b1;
      rd_addr = head;
    end else begin
      rd_ok_c = 1'b1;
      rd_addr = (req_q == REQ_POP_FRONT) ? head : tail;
      if (head == tail) begin
        head_next  = '0;
        tail_next  = '0;
        empty_next = 1'b1;
      end else if (req_q == REQ_POP_FRONT) begin
        head_next = head + PTR_W'(1);
      end else begin
        tail_next = tail - PTR_W'(1);
      end
      if (stored_count != '0) begin
        count_next = stored_count - CNT_W'(1);
      end
    end
    if (empty_next) begin
      count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity      <= CAPACITY_RESET;
      restrict_mode <= MODE_INPUT_RESTRICTED;
      head          <= '0;
      tail          <= '0;
      is_empty      <= 1'b1;
      stored_count  <= '0;
      status_q      <= STS_OK;
      rd_ok_q       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CAPACITY: capacity      <= cfg_data;
          CFG_MODE:     restrict_mode <= cfg_data[0];
          default:      ;
        endcase
      end
      if (cmd.exec) begin
        head         <= head_next;
        tail         <= tail_next;
        is_empty     <= empty_next;
        stored_count <= count_next;
        status_q     <= sts_c;
        rd_ok_q      <= rd_ok_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req_type;
      val_q <= push_value;
    end
  end

  ade_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (PTR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (cmd.exec && wr_c),
    .wr_addr (wr_addr),
    .wr_data (DATA_WIDTH'(64'(val_q))),
    .rd_en   (cmd.exec),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_wide    = 64'(rd_data);
  assign status     = status_q;
  assign count      = stored_count;
  assign read_value = rd_ok_q ? rd_wide[VAL_W-1:0] : '0;

`include "array_deque_engine_top_assert.svh"

  `ADE_ASSERT_NOW(a_empty_clear, is_empty, (stored_count == '0) && (head == '0) && (tail == '0), "empty deque with stale state")

endmodule

[rtl/array_deque_engine_top.sv]
// Array deque engine: a linear, non-wrapping deque over a slot memory.
// Input channel (in_valid/in_ready) carries one request item: req_type
// (push rear, push front, pop front, pop rear, peek front) and push_value.
// Output channel (out_valid/out_ready) returns exactly one item per request:
// status, read_value (popped or peeked element, else zero) and count.
// Config channel (cfg_valid/cfg_ready, always ready) writes capacity at
// index 0 and restrict_mode at index 1; write it only while no request is
// in flight.
// A request is taken in the idle state; the execute state applies the
// decision and issues the slot access; the output state shows the result
// item once the registered slot read is back.
// One request is in flight at a time: in_ready is low from acceptance until
// the result item is taken. A stalled receiver holds the result item and
// the block takes no new request until it leaves.
// Reset: deque empty, positions zero, capacity 256, input restricted mode.
// Slot contents are not cleared; read_value is zero unless an occupied slot was popped or peeked.
module array_deque_engine_top
  import ade_pkg::*;
#(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [REQ_W-1:0]        req_type,
  input  logic signed [VAL_W-1:0] push_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STS_W-1:0]        status,
  output logic signed [VAL_W-1:0] read_value,
  output logic [CNT_W-1:0]        count,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CAP_W-1:0]        cfg_data
);

  ade_cmd_t cmd;

  // Config writes go straight into registers, so never back-pressure them.
  assign cfg_ready = 1'b1;

  ade_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ade_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .req_type   (req_type),
    .push_value (push_value),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .status     (status),
    .read_value (read_value),
    .count      (count)
  );

endmodule
